// ===== hdl/fqrl_pkg.sv =====
// Package for the fair-queue ready list scheduler.
// Holds the sizing default, the request mode and result status codes, and the FSM states.
// No dependencies.
package fqrl_pkg;

    localparam int MAX_CHANNELS_DEF = 16;

    localparam logic MODE_READY   = 1'b0;
    localparam logic MODE_RECEIVE = 1'b1;

    typedef enum logic [1:0] {
        ST_SERVED   = 2'd0,
        ST_NONE     = 2'd1,
        ST_ACCEPTED = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SHIFT
    } t_state;

endpackage

// ===== hdl/fqrl_req_if.sv =====
// Request channel of the fair-queue scheduler: valid/ready plus the request fields.
// Standalone; no package needed.
interface fqrl_req_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic [7:0] channel_id;
    logic       drained;

    modport source (output valid, output mode, output channel_id, output drained,
                    input ready);
    modport sink   (input valid, input mode, input channel_id, input drained,
                    output ready);
endinterface

// ===== hdl/fqrl_rsp_if.sv =====
// Result channel of the fair-queue scheduler: valid/ready plus the result fields.
// Uses fqrl_pkg for the status type.
interface fqrl_rsp_if;
    logic             valid;
    logic             ready;
    fqrl_pkg::t_status status;
    logic [7:0]       served_channel;
    logic             first_ready;

    modport source (output valid, output status, output served_channel,
                    output first_ready, input ready);
    modport sink   (input valid, input status, input served_channel,
                    input first_ready, output ready);
endinterface

// ===== hdl/fqrl_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module fqrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/fair_queue_ready_list_top.sv =====
// Round-robin receive scheduler over an ordered list of ready channels.
// Depends on fqrl_pkg, fqrl_req_if, fqrl_rsp_if and fqrl_ram.

// A ready request (mode 0) appends its channel id at the end of the list and
// answers in the next cycle: accepted (first_ready set when the list was
// empty) or full with the id dropped. A receive request (mode 1) on an empty
// list answers in the next cycle. A receive on a non-empty list reads the list
// RAM at the serve position, gets the id in S_READ and answers from the answer
// register after that; without drained the position advances and the block
// returns to idle as the answer is loaded. With drained the served entry is
// erased by moving every later entry down one place, one RAM word per cycle,
// so the block stays busy until the last later entry has moved. There is a
// single answer register, so a new request is taken no earlier than the cycle
// in which the previous answer is taken. No clearing pass after reset.
module fair_queue_ready_list_top #(
    parameter int MAX_CHANNELS = fqrl_pkg::MAX_CHANNELS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    fqrl_req_if.sink   i_req,
    fqrl_rsp_if.source o_rsp
);
    import fqrl_pkg::*;

    localparam int AW = $clog2(MAX_CHANNELS);
    localparam int CW = $clog2(MAX_CHANNELS + 1);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_shift_idx, n_shift_idx;
    logic          r_drained, n_drained;
    logic          r_out_valid, n_out_valid;
    t_status       r_out_status, n_out_status;
    logic [7:0]    r_out_served, n_out_served;
    logic          r_out_first, n_out_first;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    logic          in_ready;
    logic          accept;
    logic          list_full;
    logic          list_empty;
    logic          pos_more;
    logic          shift_more;

    fqrl_ram #(
        .WIDTH (8),
        .DEPTH (MAX_CHANNELS)
    ) u_list (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign accept     = i_req.valid && in_ready;
    assign list_full  = (r_count == CW'(MAX_CHANNELS));
    assign list_empty = (r_count == '0);
    // entry behind the serve position exists (count not yet decremented)
    assign pos_more   = ((CW'(r_pos) + CW'(1)) < r_count);
    // another entry left to move down (count already decremented)
    assign shift_more = ((CW'(r_shift_idx) + CW'(1)) < r_count);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req.mode == MODE_RECEIVE) && !list_empty) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if (r_drained && pos_more) begin
                    n_state = S_SHIFT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (!shift_more) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        in_ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    end

    // datapath and list RAM control
    always_comb begin
        n_count      = r_count;
        n_pos        = r_pos;
        n_shift_idx  = r_shift_idx;
        n_drained    = r_drained;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_status = r_out_status;
        n_out_served = r_out_served;
        n_out_first  = r_out_first;
        ram_we       = 1'b0;
        ram_waddr    = r_shift_idx;
        ram_wdata    = ram_rdata;
        ram_raddr    = r_pos;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.mode == MODE_READY) begin
                        n_out_valid  = 1'b1;
                        n_out_served = '0;
                        if (list_full) begin
                            n_out_status = ST_FULL;
                            n_out_first  = 1'b0;
                        end else begin
                            ram_we       = 1'b1;
                            ram_waddr    = r_count[AW-1:0];
                            ram_wdata    = i_req.channel_id;
                            n_count      = r_count + CW'(1);
                            n_out_status = ST_ACCEPTED;
                            n_out_first  = list_empty;
                        end
                    end else if (list_empty) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_NONE;
                        n_out_served = '0;
                        n_out_first  = 1'b0;
                    end else begin
                        ram_raddr = r_pos;
                        n_drained = i_req.drained;
                    end
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_out_status = ST_SERVED;
                n_out_served = ram_rdata;
                n_out_first  = 1'b0;
                if (r_drained) begin
                    n_count = r_count - CW'(1);
                    if (pos_more) begin
                        // hold position on the successor; start the move-down
                        ram_raddr   = r_pos + AW'(1);
                        n_shift_idx = r_pos;
                    end else begin
                        n_pos = '0;
                    end
                end else if (pos_more) begin
                    n_pos = r_pos + AW'(1);
                end else begin
                    n_pos = '0;
                end
            end
            S_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = r_shift_idx;
                ram_wdata = ram_rdata;
                if (shift_more) begin
                    ram_raddr   = AW'(CW'(r_shift_idx) + CW'(2));
                    n_shift_idx = r_shift_idx + AW'(1);
                end
            end
            default: begin
                n_out_valid = r_out_valid && !o_rsp.ready;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pos       <= n_pos;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift_idx  <= n_shift_idx;
        r_drained    <= n_drained;
        r_out_status <= n_out_status;
        r_out_served <= n_out_served;
        r_out_first  <= n_out_first;
    end

    assign i_req.ready          = in_ready;
    assign o_rsp.valid          = r_out_valid;
    assign o_rsp.status         = r_out_status;
    assign o_rsp.served_channel = r_out_served;
    assign o_rsp.first_ready    = r_out_first;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_CHANNELS))
        else $error("entry count above list capacity");

    a_pos_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((list_empty && r_pos == '0) || (CW'(r_pos) < r_count)))
        else $error("serve position outside the list");

    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("answer register busy when a served id arrives");

    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_req.mode == MODE_READY) && !list_full)
            |=> (r_count == $past(r_count) + CW'(1)))
        else $error("accepted append did not grow the list");
`endif

endmodule
